// File: rtl/ohb_pkg.sv
package ohb_pkg;

   localparam int CAPACITY    = 32;
   localparam int ID_WIDTH    = 16;
   localparam int VALUE_WIDTH = 32;

   localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   localparam int CMD_W       = 2;
   localparam int TAG_ID_W    = 16;
   localparam int TAG_VALUE_W = 32;
   localparam int MAX_COUNT_W = 7;
   localparam int STORED_W    = 7;
   localparam int DROP_W      = 32;

   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(CAPACITY - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

   typedef enum logic [CMD_W-1:0] {
      CMD_RECORD   = 2'd0,
      CMD_RECENT   = 2'd1,
      CMD_SNAPSHOT = 2'd2
   } cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic rec_wr;
      logic run_load;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic run_last;
   } ctrl_stat_type;

endpackage

// File: rtl/ohb_if.sv
interface ohb_req_if import ohb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CMD_W-1:0]       cmd;
   logic [TAG_ID_W-1:0]    tag_id;
   logic [TAG_VALUE_W-1:0] tag_value;
   logic [MAX_COUNT_W-1:0] max_count;

   modport source (output valid, cmd, tag_id, tag_value, max_count, input ready);
   modport sink   (input valid, cmd, tag_id, tag_value, max_count, output ready);
endinterface

interface ohb_rsp_if import ohb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   entry_valid;
   logic [TAG_ID_W-1:0]    out_tag_id;
   logic [TAG_VALUE_W-1:0] out_tag_value;
   logic [STORED_W-1:0]    stored_count;
   logic [DROP_W-1:0]      dropped_total;
   logic                   last;

   modport source (output valid, entry_valid, out_tag_id, out_tag_value, stored_count,
                   dropped_total, last, input ready);
   modport sink   (input valid, entry_valid, out_tag_id, out_tag_value, stored_count,
                   dropped_total, last, output ready);
endinterface

// File: rtl/ohb_ctrl.sv
module ohb_ctrl import ohb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_ready,
   input  ctrl_stat_type    stat,
   output ctrl_cmd_type     ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_cmd) inside
                  CMD_RECORD: begin
                     ctl.rec_wr = 1'b1;
                  end
                  CMD_RECENT, CMD_SNAPSHOT: begin
                     ctl.run_load = 1'b1;
                     state_in     = ST_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (stat.out_free) begin
               ctl.emit = 1'b1;
               if (stat.run_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/ohb_datapath.sv
module ohb_datapath import ohb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           ctl,
   output ctrl_stat_type          stat,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [TAG_ID_W-1:0]    req_tag_id,
   input  logic [TAG_VALUE_W-1:0] req_tag_value,
   input  logic [MAX_COUNT_W-1:0] req_max_count,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_entry_valid,
   output logic [TAG_ID_W-1:0]    rsp_out_tag_id,
   output logic [TAG_VALUE_W-1:0] rsp_out_tag_value,
   output logic [STORED_W-1:0]    rsp_stored_count,
   output logic [DROP_W-1:0]      rsp_dropped_total,
   output logic                   rsp_last
);

   localparam int SUM_W = COUNT_W + 1;

   logic [ID_WIDTH-1:0]    mem_id    [CAPACITY];
   logic [VALUE_WIDTH-1:0] mem_value [CAPACITY];
   logic [ID_WIDTH-1:0]    rd_id_ff;
   logic [VALUE_WIDTH-1:0] rd_value_ff;

   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [DROP_W-1:0]  drop_ff, drop_in;
   logic               out_valid_ff, out_valid_in;

   logic               recent_ff, recent_in;
   logic               empty_ff, empty_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic [SLOT_W-1:0]  addr_ff, addr_in;
   logic               out_entry_valid_ff, out_entry_valid_in;
   logic               out_last_ff, out_last_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [DROP_W-1:0]  out_drop_ff, out_drop_in;

   logic [SLOT_W-1:0]      head_next_slot, newest_slot, oldest_slot;
   logic [SLOT_W-1:0]      addr_fwd, addr_back;
   logic [SUM_W-1:0]       head_ext, fill_ext, oldest_sum;
   logic [MAX_COUNT_W-1:0] fill_wide, recent_n;
   logic [COUNT_W-1:0]     run_count;
   logic                   is_recent;

   assign head_next_slot = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign newest_slot    = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign addr_fwd       = (addr_ff == LAST_SLOT) ? '0 : addr_ff + 1'b1;
   assign addr_back      = (addr_ff == '0) ? LAST_SLOT : addr_ff - 1'b1;

   assign head_ext    = SUM_W'(head_ff);
   assign fill_ext    = SUM_W'(fill_ff);
   assign oldest_sum  = (head_ext >= fill_ext) ? head_ext - fill_ext
                                               : head_ext + SUM_W'(CAPACITY) - fill_ext;
   assign oldest_slot = oldest_sum[SLOT_W-1:0];

   assign is_recent = (req_cmd == CMD_RECENT);
   assign fill_wide = MAX_COUNT_W'(fill_ff);
   assign recent_n  = (req_max_count < fill_wide) ? req_max_count : fill_wide;
   assign run_count = is_recent ? COUNT_W'(recent_n) : fill_ff;

   assign stat.out_free = !out_valid_ff || rsp_ready;
   assign stat.run_last = (remain_ff <= COUNT_W'(1));

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      drop_in = drop_ff;
      if (ctl.rec_wr) begin
         head_in = head_next_slot;
         if (fill_ff == FULL_COUNT) begin
            if (drop_ff != '1) begin
               drop_in = drop_ff + 1'b1;
            end
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_comb begin
      recent_in          = recent_ff;
      empty_in           = empty_ff;
      remain_in          = remain_ff;
      addr_in            = addr_ff;
      out_entry_valid_in = out_entry_valid_ff;
      out_last_in        = out_last_ff;
      out_count_in       = out_count_ff;
      out_drop_in        = out_drop_ff;
      out_valid_in       = out_valid_ff && !rsp_ready;
      if (ctl.run_load) begin
         recent_in = is_recent;
         empty_in  = (run_count == '0);
         remain_in = run_count;
         addr_in   = is_recent ? newest_slot : oldest_slot;
      end
      if (ctl.emit) begin
         out_valid_in       = 1'b1;
         out_entry_valid_in = !empty_ff;
         out_last_in        = stat.run_last;
         out_count_in       = fill_ff;
         out_drop_in        = drop_ff;
         remain_in          = remain_ff - 1'b1;
         addr_in            = recent_ff ? addr_back : addr_fwd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         drop_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      recent_ff          <= recent_in;
      empty_ff           <= empty_in;
      remain_ff          <= remain_in;
      addr_ff            <= addr_in;
      out_entry_valid_ff <= out_entry_valid_in;
      out_last_ff        <= out_last_in;
      out_count_ff       <= out_count_in;
      out_drop_ff        <= out_drop_in;
   end

   // ring storage: write on record, registered read on emit
   always_ff @(posedge clock) begin
      if (ctl.rec_wr) begin
         mem_id[head_ff]    <= ID_WIDTH'(req_tag_id);
         mem_value[head_ff] <= VALUE_WIDTH'(req_tag_value);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rd_id_ff    <= mem_id[addr_ff];
         rd_value_ff <= mem_value[addr_ff];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_entry_valid   = out_entry_valid_ff;
   assign rsp_out_tag_id    = out_entry_valid_ff ? TAG_ID_W'(rd_id_ff) : '0;
   assign rsp_out_tag_value = out_entry_valid_ff ? TAG_VALUE_W'(rd_value_ff) : '0;
   assign rsp_stored_count  = STORED_W'(out_count_ff);
   assign rsp_dropped_total = out_drop_ff;
   assign rsp_last          = out_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("fill count above capacity");

   a_head_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff != FULL_COUNT |-> head_ff == SLOT_W'(fill_ff))
      else $error("head out of step with fill count before first wrap");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      drop_ff != '0 |-> fill_ff == FULL_COUNT)
      else $error("drops counted while ring not full");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (!out_valid_ff || rsp_ready))
      else $error("emit into an occupied output register");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      ctl.rec_wr |-> !(ctl.emit || ctl.run_load))
      else $error("record overlaps a read run");

endmodule

// File: rtl/overwrite_ring_history_buffer_top.sv
// channel   dir  handshake      payload
// req_ch    in   valid/ready    cmd, tag_id, tag_value, max_count
// rsp_ch    out  valid/ready    entry_valid, out_tag_id, out_tag_value,
//                               stored_count, dropped_total, last
//
// A record request is written to the ring; cmd 3 is accepted and dropped.
// A read request gives n results (one result for an empty read), one ring read per
// cycle while the output register is free, through the single registered read port.
// Synchronous reset clears head, fill count, drop counter and control; no clearing pass.
// A stalled result holds in the output register and pauses a read run for as long
// as it waits; once the final result of a run is registered, the next request is
// taken while that result waits.
module overwrite_ring_history_buffer_top import ohb_pkg::*; (
   input logic        clock,
   input logic        reset,
   ohb_req_if.sink    req_ch,
   ohb_rsp_if.source  rsp_ch
);

   ctrl_cmd_type  ctl;
   ctrl_stat_type stat;
   logic          req_ready;

   assign req_ch.ready = req_ready;

   ohb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   ohb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .stat              (stat),
      .req_cmd           (req_ch.cmd),
      .req_tag_id        (req_ch.tag_id),
      .req_tag_value     (req_ch.tag_value),
      .req_max_count     (req_ch.max_count),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_entry_valid   (rsp_ch.entry_valid),
      .rsp_out_tag_id    (rsp_ch.out_tag_id),
      .rsp_out_tag_value (rsp_ch.out_tag_value),
      .rsp_stored_count  (rsp_ch.stored_count),
      .rsp_dropped_total (rsp_ch.dropped_total),
      .rsp_last          (rsp_ch.last)
   );

endmodule

// File: verif/overwrite_ring_history_buffer_top_tb.sv
module overwrite_ring_history_buffer_top_tb import ohb_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 320;
   localparam int HOLDOFF_CYCLES  = 300;
   localparam int CYCLE_LIMIT     = 500000;

   typedef struct {
      logic                   entry_valid;
      logic [TAG_ID_W-1:0]    tag_id;
      logic [TAG_VALUE_W-1:0] tag_value;
      logic [STORED_W-1:0]    stored_count;
      logic [DROP_W-1:0]      dropped_total;
      logic                   last;
   } ring_result_type;

   typedef enum {RX_OPEN, RX_COIN, RX_LIGHT, RX_PERIODIC} rx_mode_type;

   class ring_scoreboard_type;
      logic [ID_WIDTH-1:0]    slot_id [CAPACITY];
      logic [VALUE_WIDTH-1:0] slot_value [CAPACITY];
      int unsigned            head;
      int unsigned            fill;
      logic [DROP_W-1:0]      drops;
      ring_result_type        pending[$];
      int                     errors;
      int                     checked;
      int                     records;
      int                     recents;
      int                     snapshots;
      int                     ignored;

      function new();
         head = 0;
         fill = 0;
         drops = '0;
         errors = 0;
         checked = 0;
         records = 0;
         recents = 0;
         snapshots = 0;
         ignored = 0;
      endfunction

      function void push_read(logic valid, int unsigned slot, logic is_last);
         ring_result_type r;
         r.entry_valid   = valid;
         r.tag_id        = valid ? TAG_ID_W'(slot_id[slot]) : '0;
         r.tag_value     = valid ? TAG_VALUE_W'(slot_value[slot]) : '0;
         r.stored_count  = STORED_W'(fill);
         r.dropped_total = drops;
         r.last          = is_last;
         pending = {pending, r};
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [TAG_ID_W-1:0] id,
                                 logic [TAG_VALUE_W-1:0] value,
                                 logic [MAX_COUNT_W-1:0] max_count);
         int unsigned n;
         int unsigned oldest;
         int unsigned slot;
         if (cmd == CMD_RECORD) begin
            records++;
            if (fill >= CAPACITY) begin
               if (drops != '1)
                  drops++;
            end else begin
               fill++;
            end
            slot_id[head]    = id[ID_WIDTH-1:0];
            slot_value[head] = value[VALUE_WIDTH-1:0];
            head = (head + 1) % CAPACITY;
            return;
         end
         if (cmd == CMD_UNUSED) begin
            ignored++;
            return;
         end
         if (cmd == CMD_RECENT) begin
            recents++;
            n = (max_count < fill) ? max_count : fill;
         end else begin
            snapshots++;
            n = fill;
         end
         if (n > CAPACITY)
            n = CAPACITY;
         if (n == 0) begin
            push_read(1'b0, 0, 1'b1);
            return;
         end
         oldest = (head + CAPACITY - fill) % CAPACITY;
         for (int unsigned i = 0; i < n; i++) begin
            if (cmd == CMD_RECENT)
               slot = (head + CAPACITY - 1 - i) % CAPACITY;
            else
               slot = (oldest + i) % CAPACITY;
            push_read(1'b1, slot, (i + 1 == n));
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $display("%0t %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(ring_result_type got);
         ring_result_type want;
         if (pending.size() == 0) begin
            $display("%0t unexpected result: expected none, got id %0h value %0h last %0b",
                     $time, got.tag_id, got.tag_value, got.last);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
         compare_field("out_tag_id", 32'(want.tag_id), 32'(got.tag_id));
         compare_field("out_tag_value", want.tag_value, got.tag_value);
         compare_field("stored_count", 32'(want.stored_count), 32'(got.stored_count));
         compare_field("dropped_total", want.dropped_total, got.dropped_total);
         compare_field("last", 32'(want.last), 32'(got.last));
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   holdoff_asks = 0;
   int   holdoff_seen = 0;
   int   holdoff_left = 0;
   int   mode_left = 0;
   rx_mode_type rx_mode = RX_OPEN;

   ring_scoreboard_type sb = new();

   ohb_req_if req_ch();
   ohb_rsp_if rsp_ch();

   overwrite_ring_history_buffer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result('{rsp_ch.entry_valid, rsp_ch.out_tag_id, rsp_ch.out_tag_value,
                              rsp_ch.stored_count, rsp_ch.dropped_total, rsp_ch.last});
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.cmd, req_ch.tag_id, req_ch.tag_value, req_ch.max_count);
      end
   end

   // receiver: rotating stall patterns plus a single long hold-off
   always @(posedge clock) begin
      if (holdoff_seen != holdoff_asks) begin
         holdoff_seen = holdoff_asks;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 150);
      end else begin
         mode_left--;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:     rsp_ch.ready <= 1'b1;
            RX_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_LIGHT:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default:     rsp_ch.ready <= ((cycle_count % 7) >= 3);
         endcase
      end
   end

   task automatic offer(input logic [CMD_W-1:0] cmd, input logic [TAG_ID_W-1:0] id,
                        input logic [TAG_VALUE_W-1:0] value,
                        input logic [MAX_COUNT_W-1:0] max_count);
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= cmd;
      req_ch.tag_id    <= id;
      req_ch.tag_value <= value;
      req_ch.max_count <= max_count;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic pause(input int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      pause(1);
      while (sb.pending.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_request(output logic [CMD_W-1:0] cmd,
                                 output logic [TAG_ID_W-1:0] id,
                                 output logic [TAG_VALUE_W-1:0] value,
                                 output logic [MAX_COUNT_W-1:0] max_count);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         cmd = CMD_RECORD;
      else if (pick < 80)
         cmd = CMD_RECENT;
      else if (pick < 93)
         cmd = CMD_SNAPSHOT;
      else
         cmd = CMD_UNUSED;
      case ($urandom_range(0, 7))
         0:       id = '0;
         1:       id = '1;
         default: id = TAG_ID_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 7))
         0:       value = '0;
         1:       value = '1;
         default: value = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0:       max_count = '0;
         1:       max_count = MAX_COUNT_W'($urandom_range(65, 127));
         2:       max_count = MAX_COUNT_W'(CAPACITY);
         default: max_count = MAX_COUNT_W'($urandom_range(1, 40));
      endcase
   endtask

   initial begin
      int                     sent;
      int                     burst_left;
      logic [CMD_W-1:0]       cmd;
      logic [TAG_ID_W-1:0]    id;
      logic [TAG_VALUE_W-1:0] value;
      logic [MAX_COUNT_W-1:0] max_count;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.cmd       = CMD_RECORD;
      req_ch.tag_id    = '0;
      req_ch.tag_value = '0;
      req_ch.max_count = '0;
      rsp_ch.ready     = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty ring reads, ignored command, extremes of every field
      offer(CMD_SNAPSHOT, '1, '1, '1);
      offer(CMD_RECENT, '0, '0, 7'd5);
      offer(CMD_RECENT, '0, '0, '0);
      offer(CMD_UNUSED, '1, '1, '1);
      offer(CMD_RECORD, '0, '0, '0);
      offer(CMD_RECORD, '1, '1, '1);
      offer(CMD_RECORD, 16'h5a5a, 32'h8000_0001, 7'd64);
      offer(CMD_RECENT, '1, '1, '0);
      offer(CMD_RECENT, '0, '0, 7'd1);
      offer(CMD_RECENT, '0, '0, 7'd3);
      offer(CMD_RECENT, '0, '0, '1);
      offer(CMD_RECENT, '0, '0, 7'd64);
      offer(CMD_SNAPSHOT, '0, '0, '0);
      offer(CMD_UNUSED, '0, '0, '0);
      offer(CMD_RECORD, 16'ha5a5, 32'h7fff_fffe, 7'd2);
      offer(CMD_RECENT, '0, '0, 7'd65);
      offer(CMD_SNAPSHOT, '1, '1, 7'd127);
      drain_results();

      sent = 0;
      burst_left = $urandom_range(1, 16);
      while (sent < RANDOM_REQUESTS) begin
         random_request(cmd, id, value, max_count);
         offer(cmd, id, value, max_count);
         if (cmd != CMD_UNUSED) begin
            sent++;
            if (sent == 100)
               holdoff_asks++;
            if (sent == 200)
               drain_results();
         end
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0)
               pause($urandom_range(1, 6));
         end
      end
      drain_results();
      repeat (40) @(posedge clock);

      if (sb.pending.size() != 0) begin
         $display("%0t %0d expected results never arrived", $time, sb.pending.size());
         sb.errors++;
      end
      $display("Covered %0d records, %0d recent reads, %0d snapshots, %0d unused commands;",
               sb.records, sb.recents, sb.snapshots, sb.ignored);
      $display("%0d results compared, ring overwrote %0d entries", sb.checked, sb.drops);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
